// ===== hw/rtl/md5_stream_hasher_macros.svh =====
// Assertion macros for the MD5 stream hasher.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef MD5_STREAM_HASHER_MACROS_SVH
`define MD5_STREAM_HASHER_MACROS_SVH
`ifndef SYNTH
// Check that a property holds at every rising clock edge outside reset
`define MD5SH_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never occurs outside reset
`define MD5SH_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define MD5SH_ASSERT(name, clk, rst_n, prop, msg)
`define MD5SH_NEVER(name, clk, rst_n, cond, msg)
`endif
`endif

// ===== hw/rtl/md5sh_pkg.sv =====
// Shared types, constants and round tables of the MD5 stream hasher.
// No dependencies; imported by every module of the block.
package md5sh_pkg;

  // Word queue between the byte front end and the compression core
  localparam int unsigned QDepth = 2;  // power of two: pointers wrap by overflow
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = QPtrW + 1;

  // Word position in a block where the bit length starts
  localparam logic [3:0] LenWordPos = 4'd14;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  // One 32-bit message word, flagged when it closes the final block of a message
  typedef struct packed {
    logic        last;
    logic [31:0] word;
  } q_entry_t;

  // Additive round constant
  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] k;
    case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // Left rotate amount, set by phase and round position mod 4
  function automatic logic [4:0] rot_amt(input logic [5:0] r);
    logic [4:0] s;
    case ({r[5:4], r[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // Message word used by a round; arithmetic is mod 16 in four bits
  function automatic logic [3:0] msg_idx(input logic [5:0] r);
    logic [3:0] r4;
    logic [3:0] g;
    r4 = r[3:0];
    case (r[5:4])
      2'd0:    g = r4;
      2'd1:    g = 4'(r4 * 4'd5 + 4'd1);
      2'd2:    g = 4'(r4 * 4'd3 + 4'd5);
      default: g = 4'(r4 * 4'd7);
    endcase
    return g;
  endfunction

endpackage

// ===== hw/rtl/md5sh_front.sv =====
// Front end: accepts bytes and finish commands, packs little-endian words,
// generates MD5 padding and length words. Depends on md5sh_pkg.
module md5sh_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  logic                kind_i,
  input  logic [7:0]          data_byte_i,
  output logic                full_o,
  input  logic                q_full_i,
  output logic                q_push_o,
  output md5sh_pkg::q_entry_t q_entry_o
);
  import md5sh_pkg::*;

  typedef enum logic [1:0] {
    StData,
    StPadZero,
    StLenLo,
    StLenHi
  } state_e;

  state_e      state_q, state_d;
  logic [60:0] cnt_q, cnt_d;
  logic [23:0] acc_q, acc_d;
  logic [3:0]  wp_q, wp_d;

  logic        accept;
  logic [1:0]  bpos;
  logic [31:0] acc_ext;
  logic [31:0] pad_word;
  logic [3:0]  wp_first;

  assign full_o = (state_q != StData) || q_full_i;
  assign accept = push_i && !full_o;
  assign bpos   = cnt_q[1:0];
  assign acc_ext  = {8'h00, acc_q};
  assign wp_first = cnt_q[5:2] + 4'd1;

  // Build the first padding word: kept bytes, then the pad marker, then zeros
  always_comb begin
    pad_word = '0;
    for (int i = 0; i < 4; i++) begin
      if (2'(i) < bpos) begin
        pad_word[8*i +: 8] = acc_ext[8*i +: 8];
      end else if (2'(i) == bpos) begin
        pad_word[8*i +: 8] = PadByte;
      end
    end
  end

  // Sequence data packing and padding
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    acc_d     = acc_q;
    wp_d      = wp_q;
    q_push_o  = 1'b0;
    q_entry_o = '{last: 1'b0, word: 32'h0};
    case (state_q)
      StData: begin
        if (accept && !kind_i) begin
          cnt_d = cnt_q + 61'd1;
          case (bpos)
            2'd0: acc_d[7:0]   = data_byte_i;
            2'd1: acc_d[15:8]  = data_byte_i;
            2'd2: acc_d[23:16] = data_byte_i;
            default: begin
              q_push_o  = 1'b1;
              q_entry_o = '{last: 1'b0, word: {data_byte_i, acc_q}};
            end
          endcase
        end else if (accept && kind_i) begin
          q_push_o  = 1'b1;
          q_entry_o = '{last: 1'b0, word: pad_word};
          wp_d      = wp_first;
          state_d   = (wp_first == LenWordPos) ? StLenLo : StPadZero;
        end
      end
      StPadZero: begin
        if (!q_full_i) begin
          q_push_o = 1'b1;
          wp_d     = wp_q + 4'd1;
          if (wp_q + 4'd1 == LenWordPos) begin
            state_d = StLenLo;
          end
        end
      end
      StLenLo: begin
        if (!q_full_i) begin
          q_push_o  = 1'b1;
          q_entry_o = '{last: 1'b0, word: {cnt_q[28:0], 3'b000}};
          state_d   = StLenHi;
        end
      end
      StLenHi: begin
        if (!q_full_i) begin
          q_push_o  = 1'b1;
          q_entry_o = '{last: 1'b1, word: cnt_q[60:29]};
          cnt_d     = '0;
          state_d   = StData;
        end
      end
      default: state_d = StData;
    endcase
  end

  // Hold state, byte count and partial word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StData;
      cnt_q   <= '0;
      acc_q   <= '0;
      wp_q    <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      acc_q   <= acc_d;
      wp_q    <= wp_d;
    end
  end

endmodule

// ===== hw/rtl/md5sh_fifo.sv =====
// Short word queue between the front end and the compression core.
// Depends on md5sh_pkg and the assertion macros header.
`include "md5_stream_hasher_macros.svh"
module md5sh_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  md5sh_pkg::q_entry_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output md5sh_pkg::q_entry_t data_o,
  output logic                empty_o
);
  import md5sh_pkg::*;

  q_entry_t         mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] count_q;
  logic             do_push, do_pop;

  assign full_o  = (count_q == QCntW'(QDepth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Advance pointers and occupancy on each transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_q + QCntW'(do_push) - QCntW'(do_pop);
    end
  end

  // Store entries; no reset needed on payload
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `MD5SH_NEVER(a_fifo_overrun, clk_i, rst_ni, push_i && full_o, "push into full word queue")
  `MD5SH_NEVER(a_fifo_count, clk_i, rst_ni, count_q > QCntW'(QDepth), "queue count out of range")

endmodule

// ===== hw/rtl/md5sh_core.sv =====
// Compression core: loads 16 words into the block buffer, runs 64 rounds,
// updates the chaining words and holds the digest. Depends on md5sh_pkg, macros.
`include "md5_stream_hasher_macros.svh"
module md5sh_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  md5sh_pkg::q_entry_t q_entry_i,
  output logic                q_pop_o,
  output logic                empty_o,
  input  logic                pop_i,
  output logic [63:0]         digest_low_o,
  output logic [63:0]         digest_high_o
);
  import md5sh_pkg::*;

  typedef enum logic [1:0] {
    StLoad,
    StRound,
    StFinal,
    StEmit
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] block_q [16];
  logic [31:0] block_d [16];
  logic [31:0] chain_q [4];
  logic [31:0] chain_d [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] a_d, b_d, c_d, d_d;
  logic [31:0] t_q, t_d;
  logic [5:0]  round_q, round_d;
  logic [3:0]  widx_q, widx_d;
  logic        last_q, last_d;
  logic        out_valid_q, out_valid_d;
  logic [63:0] dig_lo_q, dig_lo_d, dig_hi_q, dig_hi_d;

  logic [31:0] f_val;
  logic [31:0] sum;
  logic [63:0] rot_dbl;
  logic [31:0] new_b;
  logic [5:0]  round_nx;

  assign empty_o       = !out_valid_q;
  assign digest_low_o  = dig_lo_q;
  assign digest_high_o = dig_hi_q;
  assign q_pop_o       = (state_q == StLoad) && !q_empty_i;

  // One MD5 round; t_q carries K plus the message word, registered in the cycle before the round uses it
  always_comb begin
    case (round_q[5:4])
      2'd0:    f_val = (b_q & c_q) | (~b_q & d_q);
      2'd1:    f_val = (b_q & d_q) | (c_q & ~d_q);
      2'd2:    f_val = b_q ^ c_q ^ d_q;
      default: f_val = c_q ^ (b_q | ~d_q);
    endcase
    sum      = a_q + f_val + t_q;
    rot_dbl  = {sum, sum} << rot_amt(round_q);
    new_b    = b_q + rot_dbl[63:32];
    round_nx = round_q + 6'd1;
  end

  // Sequence loading, rounds, chain update and digest hand-off
  always_comb begin
    state_d     = state_q;
    block_d     = block_q;
    chain_d     = chain_q;
    a_d         = a_q;
    b_d         = b_q;
    c_d         = c_q;
    d_d         = d_q;
    t_d         = t_q;
    round_d     = round_q;
    widx_d      = widx_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    dig_lo_d    = dig_lo_q;
    dig_hi_d    = dig_hi_q;

    // Drop the digest once the receiver takes it
    if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      StLoad: begin
        if (!q_empty_i) begin
          block_d[widx_q] = q_entry_i.word;
          widx_d          = widx_q + 4'd1;
          if (widx_q == 4'd15) begin
            last_d  = q_entry_i.last;
            a_d     = chain_q[0];
            b_d     = chain_q[1];
            c_d     = chain_q[2];
            d_d     = chain_q[3];
            round_d = '0;
            t_d     = round_k(6'd0) + block_q[msg_idx(6'd0)];
            state_d = StRound;
          end
        end
      end
      StRound: begin
        a_d     = d_q;
        d_d     = c_q;
        c_d     = b_q;
        b_d     = new_b;
        round_d = round_nx;
        t_d     = round_k(round_nx) + block_q[msg_idx(round_nx)];
        if (round_q == 6'd63) begin
          state_d = StFinal;
        end
      end
      StFinal: begin
        chain_d[0] = chain_q[0] + a_q;
        chain_d[1] = chain_q[1] + b_q;
        chain_d[2] = chain_q[2] + c_q;
        chain_d[3] = chain_q[3] + d_q;
        state_d    = last_q ? StEmit : StLoad;
      end
      StEmit: begin
        if (!out_valid_q || pop_i) begin
          out_valid_d = 1'b1;
          dig_lo_d    = {chain_q[1], chain_q[0]};
          dig_hi_d    = {chain_q[3], chain_q[2]};
          chain_d[0]  = InitA;
          chain_d[1]  = InitB;
          chain_d[2]  = InitC;
          chain_d[3]  = InitD;
          state_d     = StLoad;
        end
      end
      default: state_d = StLoad;
    endcase
  end

  // Hold state, working registers and the digest output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      chain_q[0]  <= InitA;
      chain_q[1]  <= InitB;
      chain_q[2]  <= InitC;
      chain_q[3]  <= InitD;
      round_q     <= '0;
      widx_q      <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chain_q     <= chain_d;
      round_q     <= round_d;
      widx_q      <= widx_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    block_q  <= block_d;
    a_q      <= a_d;
    b_q      <= b_d;
    c_q      <= c_d;
    d_q      <= d_d;
    t_q      <= t_d;
    dig_lo_q <= dig_lo_d;
    dig_hi_q <= dig_hi_d;
  end

  `MD5SH_ASSERT(a_rose_from_emit, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q) == StEmit, "digest appeared outside emit")
  `MD5SH_ASSERT(a_emit_only_last, clk_i, rst_ni, (state_q == StEmit) |-> last_q, "emit without final block")
  `MD5SH_ASSERT(a_round_widx_zero, clk_i, rst_ni, (state_q == StRound) |-> (widx_q == 4'd0), "block load index not wrapped during rounds")

endmodule

// ===== hw/rtl/md5_stream_hasher.sv =====
// MD5 stream hasher, top level: front end, word queue and compression core.
// Depends on md5sh_pkg, md5sh_front, md5sh_fifo and md5sh_core.
//
// Usage:
//   Input queue: drive kind_i/data_byte_i with push; a transfer happens when
//   push is high and full is low. kind_i = 0 carries one message byte,
//   kind_i = 1 ends the message and requests its digest.
//   Result queue: while empty is low, digest_low_o/digest_high_o hold the
//   digest in byte order (byte 0 in bits 7:0 of digest_low_o); pop takes it.
//   Throughput: bytes enter one per cycle while the word queue has room. The
//   core loads 16 words, runs 64 rounds and does one chaining add per block.
//   The queue buffers only eight bytes, so the input stalls during the rounds.
//   Finish: full stays high while padding and length words are queued, longer
//   when the padding spills into another block; the digest shows up once the
//   core has compressed the final block.
//   A stalled receiver holds the digest; the next one waits in the core and
//   the input fills up behind it.
//   Reset: chaining words go to the standard initial values, the byte count
//   and all queues clear. No clearing pass is needed.
module md5_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [63:0] digest_low_o,
  output logic [63:0] digest_high_o
);
  import md5sh_pkg::*;

  q_entry_t q_wr_entry, q_rd_entry;
  logic     q_push, q_full, q_pop, q_empty;

  // Classify items and emit message words
  md5sh_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .kind_i      (kind_i),
    .data_byte_i (data_byte_i),
    .full_o      (full),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_entry_o   (q_wr_entry)
  );

  // Decouple front end and core
  md5sh_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wr_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rd_entry),
    .empty_o (q_empty)
  );

  // Compress blocks and deliver digests
  md5sh_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_empty_i     (q_empty),
    .q_entry_i     (q_rd_entry),
    .q_pop_o       (q_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .digest_low_o  (digest_low_o),
    .digest_high_o (digest_high_o)
  );

endmodule

// ===== sim/md5sh_tb_pkg.sv =====
// Shared types for the MD5 stream hasher testbench: item kinds and the digest record.
// No dependencies; imported by the digest checker and the testbench top.
package md5sh_tb_pkg;

  // Meaning of kind_i on the input channel
  typedef enum logic {
    KindData   = 1'b0,
    KindFinish = 1'b1
  } item_kind_e;

  // One digest as it leaves the block
  typedef struct packed {
    logic [63:0] low;
    logic [63:0] high;
  } digest_t;

  // Block position where the 64-bit bit length starts
  localparam int unsigned LenBytePos = 56;
  localparam logic [7:0]  MarkerByte = 8'h80;

endpackage

// ===== sim/md5_digest_checker.sv =====
// Digest checker for the MD5 stream hasher: mirrors the hash on every input transfer
// and compares each popped digest with the oldest predicted one. Depends on md5sh_tb_pkg.
module md5_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  input  logic        full,
  input  logic        kind_i,
  input  logic [7:0]  data_byte_i,
  input  logic        empty,
  input  logic        pop,
  input  logic [63:0] digest_low_o,
  input  logic [63:0] digest_high_o,
  output int          fail_count_o,
  output int          pending_o
);

  timeunit 1ns;
  timeprecision 1ps;

  import md5sh_tb_pkg::*;

  localparam logic [31:0] RoundK [0:63] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts: four per group of sixteen rounds
  localparam int RotBy [0:15] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  logic [31:0]   hash_chain [4];
  logic [31:0]   msg_block  [16];
  logic [60:0]   msg_len_bytes;
  digest_t       expected_digests [$];
  int            mismatches;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  // Load the standard initial chaining values for a new message
  task automatic load_iv();
    hash_chain[0] = 32'h67452301;
    hash_chain[1] = 32'hefcdab89;
    hash_chain[2] = 32'h98badcfe;
    hash_chain[3] = 32'h10325476;
    msg_len_bytes = '0;
  endtask

  // Run the 64 rounds over the current block and fold into the chain
  task automatic md5_compress();
    logic [31:0] a, b, c, d, f, sum, nb;
    int          g, r;
    a = hash_chain[0];
    b = hash_chain[1];
    c = hash_chain[2];
    d = hash_chain[3];
    for (r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      sum = a + f + RoundK[r] + msg_block[g];
      nb  = b + rotl32(sum, RotBy[(r / 16) * 4 + r % 4]);
      a = d;
      d = c;
      c = b;
      b = nb;
    end
    hash_chain[0] = hash_chain[0] + a;
    hash_chain[1] = hash_chain[1] + b;
    hash_chain[2] = hash_chain[2] + c;
    hash_chain[3] = hash_chain[3] + d;
  endtask

  // Store one byte little-endian into the block; compress once the block fills
  task automatic absorb_byte(input logic [5:0] pos, input logic [7:0] v);
    msg_block[pos[5:2]][pos[1:0] * 8 +: 8] = v;
    if (pos == 6'd63) begin
      md5_compress();
    end
  endtask

  // Pad, append the bit length, queue the digest and restart the chain
  task automatic finish_message();
    logic [63:0] bit_len;
    logic [5:0]  pos;
    int          k;
    digest_t     dg;
    bit_len = {msg_len_bytes, 3'b000};
    pos     = msg_len_bytes[5:0];
    absorb_byte(pos, MarkerByte);
    pos = pos + 6'd1;
    while (pos != 6'(LenBytePos)) begin
      absorb_byte(pos, 8'h00);
      pos = pos + 6'd1;
    end
    for (k = 0; k < 8; k++) begin
      absorb_byte(6'(LenBytePos + k), bit_len[k * 8 +: 8]);
    end
    dg.low  = {hash_chain[1], hash_chain[0]};
    dg.high = {hash_chain[3], hash_chain[2]};
    expected_digests.push_back(dg);
    load_iv();
  endtask

  // Compare popped digests, then advance the model on each input transfer
  always @(posedge clk_i or negedge rst_ni) begin
    digest_t dg;
    if (!rst_ni) begin
      load_iv();
      foreach (msg_block[i]) msg_block[i] = '0;
      expected_digests.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (pop && !empty) begin
        if (expected_digests.size() == 0) begin
          $display("%0t: digest popped with none pending: expected none, got %h %h",
                   $time, digest_low_o, digest_high_o);
          mismatches++;
        end else begin
          dg = expected_digests.pop_front();
          if (digest_low_o !== dg.low) begin
            $display("%0t: digest_low mismatch: expected %h, got %h",
                     $time, dg.low, digest_low_o);
            mismatches++;
          end
          if (digest_high_o !== dg.high) begin
            $display("%0t: digest_high mismatch: expected %h, got %h",
                     $time, dg.high, digest_high_o);
            mismatches++;
          end
        end
      end
      if (push && !full) begin
        if (item_kind_e'(kind_i) == KindFinish) begin
          finish_message();
        end else begin
          absorb_byte(msg_len_bytes[5:0], data_byte_i);
          msg_len_bytes = msg_len_bytes + 61'd1;
        end
      end
      fail_count_o <= mismatches;
      pending_o <= expected_digests.size();
    end
  end

endmodule

// ===== sim/tb_md5_stream_hasher.sv =====
// Testbench top for the MD5 stream hasher: clock, reset, byte-stream stimulus and verdict.
// Depends on md5sh_tb_pkg, md5_digest_checker and the md5_stream_hasher RTL.
module tb_md5_stream_hasher;

  timeunit 1ns;
  timeprecision 1ps;

  import md5sh_tb_pkg::*;

  localparam int StallLimit  = 5000;
  localparam int HoldCycles  = 600;
  localparam int PhaseItems  = 350;
  localparam int PhaseMsgs   = 10;
  localparam int TailCycles  = 200;

  logic        clk_i;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic        kind_i;
  logic [7:0]  data_byte_i;
  logic        empty;
  logic        pop;
  logic [63:0] digest_low_o;
  logic [63:0] digest_high_o;
  int          fail_count;
  int          pending;

  int send_idle_pct;
  int recv_stall_pct;
  int hold_len;
  int hold_seq;
  int bytes_sent;
  int msgs_sent;
  int items_sent;
  int quiet_cycles;

  md5_stream_hasher uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .kind_i        (kind_i),
    .data_byte_i   (data_byte_i),
    .empty         (empty),
    .pop           (pop),
    .digest_low_o  (digest_low_o),
    .digest_high_o (digest_high_o)
  );

  md5_digest_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .kind_i        (kind_i),
    .data_byte_i   (data_byte_i),
    .empty         (empty),
    .pop           (pop),
    .digest_low_o  (digest_low_o),
    .digest_high_o (digest_high_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Drive pop at the falling edge; a requested hold-off overrides random stalls
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        hold_left = hold_len;
      end
      if (hold_left > 0) begin
        pop = 1'b0;
        hold_left--;
      end else begin
        pop = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("%0t: no transfer for %0d cycles, %0d digests pending",
                 $time, quiet_cycles, pending);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Offer one item after a random gap and hold it until the transfer; returns at a falling edge
  task automatic send_item(input item_kind_e k, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      push = 1'b0;
      @(negedge clk_i);
    end
    push        = 1'b1;
    kind_i      = k;
    data_byte_i = b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    items_sent++;
    if (k == KindFinish) begin
      msgs_sent++;
    end else begin
      bytes_sent++;
    end
    @(negedge clk_i);
  endtask

  // Random bytes followed by a finish whose data byte must be ignored
  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_item(KindData, 8'($urandom_range(255)));
    end
    send_item(KindFinish, 8'($urandom_range(255)));
  endtask

  // Favor short messages and lengths around the padding and block boundaries
  function automatic int pick_length();
    int sel;
    sel = $urandom_range(9);
    if (sel < 4) begin
      return $urandom_range(20);
    end else if (sel < 7) begin
      case ($urandom_range(9))
        0: return 55;
        1: return 56;
        2: return 57;
        3: return 63;
        4: return 64;
        5: return 65;
        6: return 119;
        7: return 120;
        8: return 127;
        default: return 128;
      endcase
    end
    return $urandom_range(140);
  endfunction

  // Stop offering until every predicted digest has been popped
  task automatic wait_drained();
    push = 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Ask the receiver process for a long hold-off
  task automatic start_hold(input int cycles);
    @(posedge clk_i);
    hold_len = cycles;
    hold_seq++;
    @(negedge clk_i);
  endtask

  initial begin
    int ph_items;
    int ph_msgs;
    rst_ni         = 1'b0;
    push           = 1'b0;
    kind_i         = KindData;
    data_byte_i    = 8'h00;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_len       = 0;
    hold_seq       = 0;
    bytes_sent     = 0;
    msgs_sent      = 0;
    items_sent     = 0;
    quiet_cycles   = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty message, "abc", single extreme bytes, back-to-back finishes
    send_item(KindFinish, 8'hff);
    send_item(KindData, 8'h61);
    send_item(KindData, 8'h62);
    send_item(KindData, 8'h63);
    send_item(KindFinish, 8'h00);
    send_item(KindData, 8'h00);
    send_item(KindFinish, 8'h00);
    send_item(KindData, 8'hff);
    send_item(KindFinish, 8'hff);
    send_item(KindData, 8'hff);
    send_item(KindData, 8'h00);
    send_item(KindFinish, 8'h5a);
    send_item(KindFinish, 8'ha5);
    wait_drained();

    // Random: four idle mixes, each closed by a full drain
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 21; recv_stall_pct = 21; end
      endcase
      ph_items = items_sent;
      ph_msgs  = msgs_sent;
      if (ph == 0) begin
        // Back up the result side so the input stalls behind it
        start_hold(HoldCycles);
        send_message(12);
        send_message(0);
        send_message(0);
        send_message(40);
        send_message(3);
      end
      while ((items_sent - ph_items) < PhaseItems || (msgs_sent - ph_msgs) < PhaseMsgs) begin
        send_message(pick_length());
      end
      wait_drained();
    end

    recv_stall_pct = 0;
    wait_drained();
    repeat (TailCycles) @(posedge clk_i);

    $display("Covered %0d bytes in %0d messages under four idle mixes,",
             bytes_sent, msgs_sent);
    $display("with a long receiver hold-off and drained pauses between phases.");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
